/* rtl/sph_cubic_spline_kernel_eval_assert.svh */
// Assertion macros shared by the checker modules of this block.
`ifndef SPH_CUBIC_SPLINE_KERNEL_EVAL_ASSERT_SVH
`define SPH_CUBIC_SPLINE_KERNEL_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sck_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sck_pkg;

  localparam int FB        = 16;
  localparam int IN_W      = FB + 2;
  localparam int OUT_W     = FB + 4;
  localparam int SD_W      = FB + 1;
  localparam int SQ_W      = 2 * SD_W;
  localparam int QT_W      = FB + 5;
  localparam int INV_W     = 13;
  localparam int NORM_BITS = 28;

  localparam int DIV_STEPS  = FB + 4;
  localparam int DIV_LAST   = DIV_STEPS + 1;
  localparam int RCP_STAGES = DIV_LAST + 2;
  localparam int PLY_STAGES = 6;
  localparam int NUM_STAGES = RCP_STAGES + PLY_STAGES;

  localparam int HALF = 1 << FB;

  localparam logic [1:0] DIM_THREE_ALT = 2'd0;
  localparam logic [1:0] DIM_ONE       = 2'd1;
  localparam logic [1:0] DIM_TWO       = 2'd2;
  localparam logic [1:0] DIM_THREE     = 2'd3;

  localparam logic signed [31:0] OUT_MAX = 32'sd524287;
  localparam logic signed [31:0] OUT_MIN = -32'sd524288;

  typedef struct packed {
    logic [SD_W-1:0]  sd;
    logic [SQ_W-1:0]  sq;
    logic             far;
    logic             outer;
    logic [INV_W-1:0] inv_f;
    logic [INV_W-1:0] inv_p;
  } rcp_out_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] gravity_potential;
    logic signed [OUT_W-1:0] gravity_force;
    logic signed [OUT_W-1:0] zeta_term;
    logic signed [OUT_W-1:0] omega_term;
    logic signed [OUT_W-1:0] kernel_slope;
    logic signed [OUT_W-1:0] kernel_value;
  } ply_res_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX;
    end else if (v < OUT_MIN) begin
      r = OUT_MIN;
    end else begin
      r = v;
    end
    return r[OUT_W-1:0];
  endfunction

  function automatic logic [NORM_BITS-1:0] norm_of(input logic [1:0] dims);
    logic [NORM_BITS-1:0] r;
    unique case (dims) inside
      DIM_ONE: r = 28'd178956971;
      DIM_TWO: r = 28'd122065228;
      DIM_THREE, DIM_THREE_ALT: r = 28'd85445659;
      default: r = 28'd85445659;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/sck_recip.sv */
`timescale 1ns / 1ps
`default_nettype none

module sck_recip import sck_pkg::*; (
  input  logic                  clk_i,
  input  logic [RCP_STAGES-1:0] en_i,
  input  logic [IN_W-1:0]       dist_i,
  output rcp_out_t              out_o
);

  localparam logic [SQ_W-1:0] NUM_F = SQ_W'(64'd1 << (2 * FB));
  localparam logic [SD_W-1:0] NUM_P = SD_W'(HALF);
  localparam logic [16:0]     RCP15_SMALL = 17'd69906;
  localparam int              PR_W = 34;

  logic [SD_W-1:0] sd_q    [0:DIV_LAST];
  logic [SQ_W-1:0] sq_q    [0:DIV_LAST];
  logic            far_q   [0:DIV_LAST];
  logic            outer_q [0:DIV_LAST];
  logic [SQ_W-1:0] rf_q    [1:DIV_LAST];
  logic [SD_W-1:0] rp_q    [1:DIV_LAST];
  logic [QT_W-1:0] qf_q    [1:DIV_LAST];
  logic [QT_W-1:0] qp_q    [1:DIV_LAST];

  logic [SD_W-1:0] sd_last_q;
  logic [SQ_W-1:0] sq_last_q;
  logic            far_last_q;
  logic            outer_last_q;
  logic [PR_W-1:0] prf_q;
  logic [PR_W-1:0] prp_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sd_q[0]    <= dist_i[SD_W-1:0];
      sq_q[0]    <= dist_i[SD_W-1:0] * dist_i[SD_W-1:0];
      far_q[0]   <= dist_i[IN_W-1];
      outer_q[0] <= dist_i[FB];
    end
  end

  logic ge_f1, ge_p1;

  always_comb begin
    ge_f1 = NUM_F >= sq_q[0];
    ge_p1 = NUM_P >= sd_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sd_q[1]    <= sd_q[0];
      sq_q[1]    <= sq_q[0];
      far_q[1]   <= far_q[0];
      outer_q[1] <= outer_q[0];
      rf_q[1]    <= ge_f1 ? (NUM_F - sq_q[0]) : NUM_F;
      rp_q[1]    <= ge_p1 ? (NUM_P - sd_q[0]) : NUM_P;
      qf_q[1]    <= QT_W'(ge_f1);
      qp_q[1]    <= QT_W'(ge_p1);
    end
  end

  for (genvar k = 2; k <= DIV_LAST; k++) begin : g_step
    logic [SQ_W:0] shf;
    logic [SD_W:0] shp;
    logic          gef;
    logic          gep;
    logic [SQ_W:0] dff;
    logic [SD_W:0] dfp;

    always_comb begin
      shf = {rf_q[k-1], 1'b0};
      shp = {rp_q[k-1], 1'b0};
      gef = shf >= {1'b0, sq_q[k-1]};
      gep = shp >= {1'b0, sd_q[k-1]};
      dff = shf - {1'b0, sq_q[k-1]};
      dfp = shp - {1'b0, sd_q[k-1]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        sd_q[k]    <= sd_q[k-1];
        sq_q[k]    <= sq_q[k-1];
        far_q[k]   <= far_q[k-1];
        outer_q[k] <= outer_q[k-1];
        rf_q[k]    <= gef ? dff[SQ_W-1:0] : shf[SQ_W-1:0];
        rp_q[k]    <= gep ? dfp[SD_W-1:0] : shp[SD_W-1:0];
        qf_q[k]    <= {qf_q[k-1][QT_W-2:0], gef};
        qp_q[k]    <= {qp_q[k-1][QT_W-2:0], gep};
      end
    end
  end

  // Rounded division by 240: add 120, drop four bits, then divide by 15.
  logic [QT_W-1:0] tf, tp;

  always_comb begin
    tf = qf_q[DIV_LAST] + QT_W'(120);
    tp = qp_q[DIV_LAST] + QT_W'(120);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[DIV_LAST+1]) begin
      sd_last_q    <= sd_q[DIV_LAST];
      sq_last_q    <= sq_q[DIV_LAST];
      far_last_q   <= far_q[DIV_LAST];
      outer_last_q <= outer_q[DIV_LAST];
      prf_q        <= tf[QT_W-1:4] * RCP15_SMALL;
      prp_q        <= tp[QT_W-1:4] * RCP15_SMALL;
    end
  end

  always_comb begin
    out_o.sd    = sd_last_q;
    out_o.sq    = sq_last_q;
    out_o.far   = far_last_q;
    out_o.outer = outer_last_q;
    out_o.inv_f = prf_q[INV_W+19:20];
    out_o.inv_p = prp_q[INV_W+19:20];
  end

endmodule

`default_nettype wire

/* rtl/sck_poly.sv */
`timescale 1ns / 1ps
`default_nettype none

module sck_poly import sck_pkg::*; (
  input  logic                  clk_i,
  input  logic [PLY_STAGES-1:0] en_i,
  input  rcp_out_t              rcp_i,
  input  logic [1:0]            dims_i,
  output ply_res_t              res_o
);

  localparam int ACC_W  = 30;
  localparam int SQ1    = SQ_W + 1;
  localparam int V_W    = 24;
  localparam int PW_W   = V_W + NORM_BITS + 1;
  localparam int PZ_W   = 55;
  localparam int PG_W   = 57;
  localparam int DIV_K  = 1 << 23;
  localparam int BIAS_Z = 5 + 10 * DIV_K;
  localparam int BIAS_G = 15 + 30 * DIV_K;
  localparam int NORM_HALF = 1 << (NORM_BITS - 1);
  localparam logic [27:0] RCP5  = 28'd214748365;
  localparam logic [28:0] RCP15 = 29'd286331154;
  localparam logic signed [ACC_W-1:0] P0 = ACC_W'(1 << SD_W);

  typedef struct packed {
    logic             far;
    logic             outer;
    logic [INV_W-1:0] inv_f;
    logic [INV_W-1:0] inv_p;
  } side_t;

  function automatic logic [SD_W-1:0] rnd(input logic [SQ_W-1:0] m);
    logic [SQ_W:0] t;
    t = {1'b0, m} + SQ1'(HALF);
    return t[SD_W +: SD_W];
  endfunction

  side_t           side_q [0:4];
  logic [SD_W-1:0] p1_q [0:2];
  logic [SD_W-1:0] p2_q [0:2];
  logic [SD_W-1:0] p3_q [0:2];
  logic [SD_W-1:0] p4_q [1:2];
  logic [SD_W-1:0] p5_q;
  logic signed [ACC_W-1:0] acc_q [0:5];
  logic signed [PW_W-1:0]  pw_q [0:2];
  logic [PZ_W-1:0]         pz_q;
  logic [PG_W-1:0]         pg_q [0:1];
  ply_res_t                res_q;

  logic [SD_W-1:0] p2_d;
  logic [SQ_W-1:0] m3, m4, m5;

  always_comb begin
    p2_d = rnd(rcp_i.sq);
    m3   = p2_d * rcp_i.sd;
    m4   = p3_q[0] * p1_q[0];
    m5   = p4_q[1] * p1_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_q[0] <= '{far: rcp_i.far, outer: rcp_i.outer,
                     inv_f: rcp_i.inv_f, inv_p: rcp_i.inv_p};
      p1_q[0]   <= rcp_i.sd;
      p2_q[0]   <= p2_d;
      p3_q[0]   <= rnd(m3);
    end
    if (en_i[1]) begin
      side_q[1] <= side_q[0];
      p1_q[1]   <= p1_q[0];
      p2_q[1]   <= p2_q[0];
      p3_q[1]   <= p3_q[0];
      p4_q[1]   <= rnd(m4);
    end
    if (en_i[2]) begin
      side_q[2] <= side_q[1];
      p1_q[2]   <= p1_q[1];
      p2_q[2]   <= p2_q[1];
      p3_q[2]   <= p3_q[1];
      p4_q[2]   <= p4_q[1];
      p5_q      <= rnd(m5);
    end
  end

  logic signed [ACC_W-1:0] P1, P2, P3, P4, P5;
  logic signed [7:0]       n8, oc0, oc1, oc2, oc3;
  logic signed [ACC_W-1:0] acc_d [0:5];

  always_comb begin
    P1 = ACC_W'(p1_q[2]);
    P2 = ACC_W'(p2_q[2]);
    P3 = ACC_W'(p3_q[2]);
    P4 = ACC_W'(p4_q[2]);
    P5 = ACC_W'(p5_q);
    n8 = (dims_i == DIM_THREE_ALT) ? 8'sd3 : $signed({6'b0, dims_i});
    if (side_q[2].outer) begin
      oc0 = -(n8 * 8'sd2);
      oc1 = 8'sd6 * (n8 + 8'sd1);
      oc2 = -(8'sd6 * (n8 + 8'sd2));
      oc3 = 8'sd2 * (n8 + 8'sd3);
      acc_d[0] = ACC_W'(2 * P0 - 6 * P1 + 6 * P2 - 2 * P3);
      acc_d[1] = ACC_W'(-3 * P0 + 6 * P1 - 3 * P2);
      acc_d[3] = ACC_W'(8 * P0 - 80 * P2 + 160 * P3 - 120 * P4 + 32 * P5);
      acc_d[4] = ACC_W'(80 * P1 - 180 * P2 + 144 * P3 - 40 * P4);
      acc_d[5] = ACC_W'(24 * P0 - 80 * P2 + 120 * P3 - 72 * P4 + 16 * P5);
    end else begin
      oc0 = -n8;
      oc1 = 8'sd0;
      oc2 = 8'sd6 * (n8 + 8'sd2);
      oc3 = -(8'sd6 * (n8 + 8'sd3));
      acc_d[0] = ACC_W'(P0 - 6 * P2 + 6 * P3);
      acc_d[1] = ACC_W'(-6 * P1 + 9 * P2);
      acc_d[3] = ACC_W'(7 * P0 - 40 * P2 + 120 * P4 - 96 * P5);
      acc_d[4] = ACC_W'(40 * P1 - 144 * P3 + 120 * P4);
      acc_d[5] = ACC_W'(21 * P0 - 40 * P2 + 72 * P4 - 48 * P5);
    end
    acc_d[2] = ACC_W'(ACC_W'(oc0) * P0 + ACC_W'(oc1) * P1 + ACC_W'(oc2) * P2 +
                      ACC_W'(oc3) * P3);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      side_q[3] <= side_q[2];
      for (int i = 0; i < 6; i++) begin
        acc_q[i] <= acc_d[i];
      end
    end
  end

  logic signed [ACC_W-1:0] tw [0:2];
  logic signed [ACC_W-1:0] xz, xg0, xg1;
  logic [NORM_BITS-1:0]    nm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tw[i] = acc_q[i] + ACC_W'(1);
    end
    xz  = acc_q[3] + ACC_W'(BIAS_Z);
    xg0 = acc_q[4] + ACC_W'(BIAS_G);
    xg1 = acc_q[5] + ACC_W'(BIAS_G);
    nm  = norm_of(dims_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      side_q[4] <= side_q[3];
      for (int i = 0; i < 3; i++) begin
        pw_q[i] <= $signed(tw[i][V_W:1]) * $signed({1'b0, nm});
      end
      pz_q    <= xz[27:1] * RCP5;
      pg_q[0] <= xg0[28:1] * RCP15;
      pg_q[1] <= xg1[28:1] * RCP15;
    end
  end

  logic signed [PW_W-1:0] rw [0:2];
  logic signed [31:0]     vz, vf, vp;
  ply_res_t               res_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rw[i] = pw_q[i] + PW_W'(NORM_HALF);
    end
    vz = 32'(pz_q[PZ_W-1:30]) - 32'(DIV_K);
    vf = 32'(pg_q[0][PG_W-1:32]) - 32'(DIV_K);
    vp = 32'(pg_q[1][PG_W-1:32]) - 32'(DIV_K);
    if (side_q[4].outer) begin
      vf = vf - 32'(side_q[4].inv_f);
      vp = vp - 32'(side_q[4].inv_p);
    end
    res_d.kernel_value      = sat_out(32'($signed(rw[0][PW_W-1:NORM_BITS])));
    res_d.kernel_slope      = sat_out(32'($signed(rw[1][PW_W-1:NORM_BITS])));
    res_d.omega_term        = sat_out(32'($signed(rw[2][PW_W-1:NORM_BITS])));
    res_d.zeta_term         = sat_out(vz);
    res_d.gravity_force     = sat_out(vf);
    res_d.gravity_potential = sat_out(vp);
    if (side_q[4].far) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* rtl/sph_cubic_spline_kernel_eval.sv */
// Cubic-spline (M4) SPH kernel evaluator.
// The slave stream takes one word per scaled distance s, unsigned Q2.16 in the
// low 18 bits of s_axis_tdata. The master stream returns one word with all six
// kernel functions as signed Q3.16 values, saturated, and zero for s of 2 or more.
// The configuration channel writes the number of dimensions (1 to 3, and 0 acts
// as 3); it is always ready and should only be written while no word is in flight.
// An accepted input word reaches the output through 23 stages of reciprocal work
// for the gravity terms (one quotient bit per divide stage) and 6 stages of power
// series, normalization and saturation. Throughput is one word per cycle unless
// the receiver stalls. Each stage holds its own valid bit and advances when it is
// empty or the stage after it advances, so a stalled receiver first fills any
// bubbles and only then stops input. The output register holds its word until it
// is taken. Reset empties the pipeline and sets the dimension register to 3.
`timescale 1ns / 1ps
`default_nettype none

module sph_cubic_spline_kernel_eval import sck_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // distance[17:0], zero fill
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // kernel_value, kernel_slope, omega_term,
                                       // zeta_term, gravity_force, gravity_potential
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i      // dimensions
);

  logic [1:0]            dims_q;
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;
  logic [NUM_STAGES-1:0] en;
  rcp_out_t              rcp;
  ply_res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIM_THREE;
    end else if (cfg_valid_i) begin
      dims_q <= cfg_data_i;
    end
  end

  for (genvar j = 0; j < NUM_STAGES; j++) begin : g_en
    assign en[j] = m_axis_tready | ~(&v_q[NUM_STAGES-1:j]);
  end

  assign v_d = {v_q[NUM_STAGES-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int j = 0; j < NUM_STAGES; j++) begin
        if (en[j]) begin
          v_q[j] <= v_d[j];
        end
      end
    end
  end

  sck_recip u_recip (
    .clk_i  (clk_i),
    .en_i   (en[RCP_STAGES-1:0]),
    .dist_i (s_axis_tdata[IN_W-1:0]),
    .out_o  (rcp)
  );

  sck_poly u_poly (
    .clk_i  (clk_i),
    .en_i   (en[NUM_STAGES-1:RCP_STAGES]),
    .rcp_i  (rcp),
    .dims_i (dims_q),
    .res_o  (res)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NUM_STAGES-1];
  assign m_axis_tdata  = res;

endmodule

`default_nettype wire

/* rtl/sck_check.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "sph_cubic_spline_kernel_eval_assert.svh"

module sck_check (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [23:0]  s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic [1:0]   cfg_data_i
);

  `SCK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Output word changed while stalled.")
  `SCK_ASSERT_NOW(a_in_free, !m_axis_tvalid || m_axis_tready, s_axis_tready, "Input blocked although the output can move.")
  `SCK_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "Configuration write not taken.")

endmodule

bind sph_cubic_spline_kernel_eval sck_check u_sck_check (.*);

`default_nettype wire

/* test/sph_cubic_spline_kernel_eval_tb.sv */
`timescale 1ns / 1ps

module sph_cubic_spline_kernel_eval_tb;
  import sck_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 900;

  typedef struct packed {
    logic signed [19:0] gravity_potential;
    logic signed [19:0] gravity_force;
    logic signed [19:0] zeta_term;
    logic signed [19:0] omega_term;
    logic signed [19:0] kernel_slope;
    logic signed [19:0] kernel_value;
  } kernel_set_t;

  typedef struct {
    logic [17:0] distance;
    logic        known;
    kernel_set_t res;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_data_i = DIM_THREE;

  kernel_set_t kernel_queue[$];
  logic [1:0]  dims_model;
  int          fail_count = 0;
  int          words_out = 0;
  int          idle_cycles = 0;
  bit          rx_stall_on = 1'b1;

  always #10 clk_i = ~clk_i;

  sph_cubic_spline_kernel_eval uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  function automatic longint fdiv(longint x, longint m);
    if (x >= 0) return x / m;
    return -((-x + m - 1) / m);
  endfunction

  function automatic longint series(longint c[6], longint p[6], longint den);
    longint acc;
    acc = 0;
    for (int k = 0; k < 6; k++) acc += c[k] * p[k];
    return fdiv(acc + den, 2 * den);
  endfunction

  function automatic longint fifteenth(longint num, longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < FRAC + 4; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return (q + 120) / 240;
  endfunction

  function automatic longint normed(longint v, longint nm);
    return fdiv(v * nm + (longint'(1) << 27), longint'(1) << 28);
  endfunction

  function automatic logic signed [19:0] clamp20(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic kernel_set_t kernel_predict(logic [17:0] distance, logic [1:0] dims);
    longint s, one, n, nm;
    longint p[6], om[6], r[6];
    longint w0i[6] = '{1, 0, -6, 6, 0, 0};
    longint w0o[6] = '{2, -6, 6, -2, 0, 0};
    longint w1i[6] = '{0, -6, 9, 0, 0, 0};
    longint w1o[6] = '{-3, 6, -3, 0, 0, 0};
    longint zti[6] = '{7, 0, -40, 0, 120, -96};
    longint zto[6] = '{8, 0, -80, 160, -120, 32};
    longint gfi[6] = '{0, 40, 0, -144, 120, 0};
    longint gfo[6] = '{0, 80, -180, 144, -40, 0};
    longint gpi[6] = '{21, 0, -40, 0, 72, -48};
    longint gpo[6] = '{24, 0, -80, 120, -72, 16};
    kernel_set_t k;
    s = distance;
    one = longint'(1) << FRAC;
    r = '{0, 0, 0, 0, 0, 0};
    om = '{0, 0, 0, 0, 0, 0};
    if (s < 2 * one) begin
      n = (dims == DIM_THREE_ALT) ? 3 : dims;
      nm = norm_of(dims);
      p[0] = longint'(1) << (FRAC + 1);
      p[1] = s;
      for (int i = 2; i < 6; i++) p[i] = (p[i-1] * s + one) >>> (FRAC + 1);
      if (s < one) begin
        om[0] = -n; om[2] = 6 * (n + 2); om[3] = -6 * (n + 3);
        r[0] = normed(series(w0i, p, 1), nm);
        r[1] = normed(series(w1i, p, 1), nm);
        r[2] = normed(series(om, p, 1), nm);
        r[3] = series(zti, p, 5);
        r[4] = series(gfi, p, 15);
        r[5] = series(gpi, p, 15);
      end else begin
        om[0] = -2 * n; om[1] = 6 * (n + 1); om[2] = -6 * (n + 2); om[3] = 2 * (n + 3);
        r[0] = normed(series(w0o, p, 1), nm);
        r[1] = normed(series(w1o, p, 1), nm);
        r[2] = normed(series(om, p, 1), nm);
        r[3] = series(zto, p, 5);
        r[4] = series(gfo, p, 15) - fifteenth(one * one, s * s);
        r[5] = series(gpo, p, 15) - fifteenth(one, s);
      end
    end
    k.kernel_value = clamp20(r[0]);
    k.kernel_slope = clamp20(r[1]);
    k.omega_term = clamp20(r[2]);
    k.zeta_term = clamp20(r[3]);
    k.gravity_force = clamp20(r[4]);
    k.gravity_potential = clamp20(r[5]);
    return k;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_distance(logic [17:0] distance);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {6'd0, distance};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    kernel_queue.push_back(kernel_predict(distance, dims_model));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (kernel_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_dimensions(logic [1:0] dims);
    drain_results();
    cfg_data_i <= dims;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    dims_model = dims;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(string name, logic signed [19:0] exp_v, logic signed [19:0] act);
    if (exp_v !== act) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", kernel_queue.size());
        $display("end of test: mismatches");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        kernel_set_t got, want;
        got = m_axis_tdata;
        words_out++;
        if (kernel_queue.size() == 0) begin
          $error("result word with no pending expectation");
          fail_count++;
        end else begin
          want = kernel_queue.pop_front();
          check_field("kernel_value", want.kernel_value, got.kernel_value);
          check_field("kernel_slope", want.kernel_slope, got.kernel_slope);
          check_field("omega_term", want.omega_term, got.omega_term);
          check_field("zeta_term", want.zeta_term, got.zeta_term);
          check_field("gravity_force", want.gravity_force, got.gravity_force);
          check_field("gravity_potential", want.gravity_potential, got.gravity_potential);
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (!rx_stall_on) m_axis_tready <= 1'b1;
      else if (m_axis_tready && gap_len() != 0) m_axis_tready <= 1'b0;
      else if (!m_axis_tready && $urandom_range(3) == 0) m_axis_tready <= 1'b1;
      else if (!m_axis_tready) m_axis_tready <= 1'b0;
      else m_axis_tready <= 1'b1;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [17:0] d;
    logic [1:0] dims_seq[4] = '{DIM_ONE, DIM_TWO, DIM_THREE_ALT, DIM_THREE};
    dims_model = DIM_THREE;
    rows.push_back('{18'd0, 1'b0, '0});
    rows.push_back('{18'd1, 1'b0, '0});
    rows.push_back('{18'd32768, 1'b0, '0});
    rows.push_back('{18'd65535, 1'b0, '0});
    rows.push_back('{18'd65536, 1'b0, '0});
    rows.push_back('{18'd65537, 1'b0, '0});
    rows.push_back('{18'd98304, 1'b0, '0});
    rows.push_back('{18'd131071, 1'b0, '0});
    rows.push_back('{18'd131072, 1'b1, '0});
    rows.push_back('{18'd131073, 1'b1, '0});
    rows.push_back('{18'd196608, 1'b1, '0});
    rows.push_back('{18'd262143, 1'b1, '0});
    rows.push_back('{18'h2AAAA, 1'b1, '0});
    rows.push_back('{18'h15555, 1'b0, '0});

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dims_seq[i]) begin
      write_dimensions(dims_seq[i]);
      foreach (rows[j]) begin
        row = rows[j];
        if (row.known) begin
          if (kernel_predict(row.distance, dims_model) !== row.res) begin
            $error("predictor disagrees with directed row for distance %0d", row.distance);
            fail_count++;
          end
        end
        send_distance(row.distance);
      end
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 225 == 0) write_dimensions(dims_seq[$urandom_range(3)]);
      rx_stall_on = (i % 150) >= 40;
      case ($urandom_range(9))
        0: d = $urandom_range(262143, 131072);
        1: d = $urandom_range(1023);
        2: d = 18'd65536 + $urandom_range(63) - 18'd32;
        3: d = 18'd131071 - $urandom_range(63);
        default: d = $urandom_range(131071);
      endcase
      send_distance(d);
    end

    rx_stall_on = 1'b1;
    drain_results();
    $display("Covered %0d result words over dimensions 0..3, near, outer and far ranges.",
             words_out);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
